// File: src/vp8_rtp_payload_extent_parser_unit_defines.svh
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser: assertion macros
// Shared concurrent checks for the parser top level.
// ----------------------------------------------------------------------------
`ifndef VP8_RTP_PAYLOAD_EXTENT_PARSER_UNIT_DEFINES_SVH
`define VP8_RTP_PAYLOAD_EXTENT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define VRPE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define VRPE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: src/vrpe_pkg.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser package
// Word types, field widths and header layout constants.
// ----------------------------------------------------------------------------
package vrpe_pkg;

  localparam int BYTE_W       = 8;
  localparam int PAYLOAD_W    = 16;
  localparam int FRAME_LEN_W  = 24;
  localparam int TS_W         = 32;
  localparam int PT_W         = 7;

  // Header end can reach 12 + 60 + 4 + 4 * 65535: 19 bits, one more for sums.
  localparam int HDR_W        = 19;
  localparam int CMP_W        = 20;

  localparam int RTP_FIXED_HDR_BYTES = 12;
  localparam int EXT_HDR_BYTES       = 4;
  localparam int EXT_LEN_HI_OFS      = 2;
  localparam int EXT_LEN_LO_OFS      = 3;
  localparam int PT_BYTE_POS         = 1;
  localparam int TS_FIRST_POS        = 4;
  localparam int TS_LAST_POS         = 7;

  // RTP first byte
  localparam int RTP_X_BIT = 4;
  localparam int RTP_P_BIT = 5;

  // VP8 payload descriptor bits
  localparam int DESC_X_BIT  = 7;
  localparam int EXT_I_BIT   = 7;
  localparam int EXT_L_BIT   = 6;
  localparam int EXT_T_BIT   = 5;
  localparam int EXT_K_BIT   = 4;
  localparam int PICID_M_BIT = 7;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_packet;
    logic              end_of_frame;
  } in_word_t;

  typedef struct packed {
    logic                   packet_ok;
    logic [PAYLOAD_W-1:0]   payload_start;
    logic [PAYLOAD_W-1:0]   payload_length;
    logic                   frame_done;
    logic                   frame_ok;
    logic [TS_W-1:0]        frame_timestamp;
    logic [PT_W-1:0]        frame_payload_type;
    logic [FRAME_LEN_W-1:0] frame_length;
  } out_word_t;

  // Per-word packet status from the parser to the frame accumulator
  typedef struct packed {
    logic                 packet_ok;
    logic [PAYLOAD_W-1:0] payload_start;
    logic [PAYLOAD_W-1:0] payload_length;
    logic                 first_hdr_ok;
    logic                 capture_pt;
    logic                 capture_ts;
  } pkt_info_t;

endpackage

// File: src/vrpe_stream_if.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser stream interface
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface vrpe_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

// File: src/vp8_rtp_payload_extent_parser_unit.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser
// Tracks RTP header and VP8 descriptor per byte and reports payload extents.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one RTP packet byte per word, with end_of_packet on the last
//   byte of each packet and end_of_frame alongside it on the frame's last one.
//   out_o delivers one word per packet: whether it is usable, where its VP8
//   payload starts and how long it is; on the frame's last packet the same
//   word also holds the frame timestamp, payload type and total length.
//   Words without end_of_packet produce nothing on out_o.
// Timing:
//   One input word per cycle, unless a last byte is held by a waiting result.
//   A word is held in the input register, then its header and descriptor checks
//   resolve into the result register, which holds each packet's result word.
// Reset:
//   Clears both registers' valid flags and all packet and frame tracking; the first packet
//   after reset opens a new frame.
// Stall:
//   While a result waits on out_o, non-final bytes keep flowing; a last byte
//   holds in the input register until the waiting result is taken.
// ----------------------------------------------------------------------------
`include "vp8_rtp_payload_extent_parser_unit_defines.svh"

module vp8_rtp_payload_extent_parser_unit #(
  parameter int LENGTH_BITS       = 16,
  parameter int FRAME_LENGTH_BITS = 24
) (
  input logic           clk_i,
  input logic           rst_ni,
  vrpe_stream_if.sink   in_i,
  vrpe_stream_if.source out_o
);
  import vrpe_pkg::*;

  logic      s1_valid;
  in_word_t  s1_word;
  in_word_t  in_word;
  logic      advance;
  logic      room;
  pkt_info_t info;
  out_word_t res_word;
  logic      res_valid;
  logic      eop_move;
  logic      res_blocked;
  logic      res_frame_ok;
  logic      res_frame_full;

  assign in_word = in_i.payload;

  vrpe_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_word_i   (in_word),
    .in_ready_o  (in_i.ready),
    .advance_i   (advance),
    .word_valid_o(s1_valid),
    .word_o      (s1_word)
  );

  // a last byte moves on only when the result register can take its word
  assign advance = s1_valid && (!s1_word.end_of_packet || room);

  vrpe_packet_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_packet_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .word_i   (s1_word),
    .info_o   (info)
  );

  vrpe_frame_accum #(
    .FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
  ) u_frame_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .word_i     (s1_word),
    .info_i     (info),
    .out_ready_i(out_o.ready),
    .out_valid_o(res_valid),
    .out_word_o (res_word),
    .room_o     (room)
  );

  assign out_o.valid   = res_valid;
  assign out_o.payload = res_word;

  assign eop_move       = advance && s1_word.end_of_packet;
  assign res_blocked    = out_o.valid && !out_o.ready;
  assign res_frame_ok   = out_o.valid && out_o.payload.frame_ok;
  assign res_frame_full = out_o.payload.frame_done && (out_o.payload.frame_length != '0);

  `VRPE_ASSERT_NEXT(a_result_follows_eop, clk_i, rst_ni, eop_move, out_o.valid)
  `VRPE_ASSERT_SAME(a_no_result_overwrite, clk_i, rst_ni, res_blocked, !eop_move)
  `VRPE_ASSERT_SAME(a_frame_ok_has_length, clk_i, rst_ni, res_frame_ok, res_frame_full)

endmodule

// File: src/vrpe_in_stage.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser input stage
// Registers each incoming word; refills in the cycle the held word moves on.
// ----------------------------------------------------------------------------
module vrpe_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  vrpe_pkg::in_word_t in_word_i,
  output logic              in_ready_o,
  input  logic              advance_i,
  output logic              word_valid_o,
  output vrpe_pkg::in_word_t word_o
);
  import vrpe_pkg::*;

  logic     valid_q, valid_d;
  in_word_t word_q;
  logic     accept;

  always_comb begin
    in_ready_o = !valid_q || advance_i;
    accept     = in_valid_i && in_ready_o;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

  assign word_valid_o = valid_q;
  assign word_o       = word_q;

endmodule

// File: src/vrpe_packet_parser.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser packet tracker
// Follows the RTP header and VP8 descriptor byte by byte and judges each
// packet on its last byte.
// ----------------------------------------------------------------------------
module vrpe_packet_parser #(
  parameter int LENGTH_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  vrpe_pkg::in_word_t  word_i,
  output vrpe_pkg::pkt_info_t info_o
);
  import vrpe_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_HDR,
    PH_EXT,
    PH_PICID,
    PH_DONE
  } phase_e;

  localparam int PW = LENGTH_BITS;
  localparam logic [PW-1:0] POS_MAX = '1;

  logic [PW-1:0]     pos_q, pos_d;
  logic [3:0]        csrc_q, csrc_d;
  logic              ext_q, ext_d;
  logic              pad_q, pad_d;
  logic [15:0]       ext_words_q, ext_words_d, ext_words_upd;
  phase_e            phase_q, phase_d, phase_upd;
  logic [PW:0]       dend_q, dend_d, dend_upd;

  logic [BYTE_W-1:0] b;
  logic [HDR_W-1:0]  pos_x, base, hdr;
  logic [PW:0]       pos_p1;
  logic [CMP_W-1:0]  size, pad, room;
  logic              ok;
  logic [PW-1:0]     len;

  always_comb begin
    b      = word_i.data_byte;
    pos_x  = HDR_W'(pos_q);
    pos_p1 = {1'b0, pos_q} + (PW+1)'(1);
    base   = HDR_W'(RTP_FIXED_HDR_BYTES) + HDR_W'({csrc_q, 2'b00});
    hdr    = base + (ext_q ? HDR_W'(EXT_HDR_BYTES) + HDR_W'({ext_words_q, 2'b00})
                           : '0);

    // first byte: CSRC count, X and P
    csrc_d = csrc_q;
    ext_d  = ext_q;
    pad_d  = pad_q;
    if (pos_q == '0) begin
      csrc_d = b[3:0];
      ext_d  = b[RTP_X_BIT];
      pad_d  = b[RTP_P_BIT];
    end

    ext_words_upd = ext_words_q;
    if (ext_q) begin
      if (pos_x == base + HDR_W'(EXT_LEN_HI_OFS)) begin
        ext_words_upd = {b, 8'h00};
      end else if (pos_x == base + HDR_W'(EXT_LEN_LO_OFS)) begin
        ext_words_upd = {ext_words_q[15:8], b};
      end
    end

    // descriptor walk
    phase_upd = phase_q;
    dend_upd  = dend_q;
    unique case (phase_q)
      PH_WAIT_HDR: begin
        if (pos_x == hdr) begin
          if (b[DESC_X_BIT]) begin
            dend_upd  = pos_p1 + (PW+1)'(1);
            phase_upd = PH_EXT;
          end else begin
            dend_upd  = pos_p1;
            phase_upd = PH_DONE;
          end
        end
      end
      PH_EXT: begin
        dend_upd  = pos_p1 + (PW+1)'(b[EXT_L_BIT])
                  + (PW+1)'(b[EXT_T_BIT] | b[EXT_K_BIT])
                  + (PW+1)'(b[EXT_I_BIT]);
        phase_upd = b[EXT_I_BIT] ? PH_PICID : PH_DONE;
      end
      PH_PICID: begin
        dend_upd  = dend_q + (PW+1)'(b[PICID_M_BIT]);
        phase_upd = PH_DONE;
      end
      PH_DONE: begin
      end
    endcase

    // packet verdict on the last byte
    size = CMP_W'(pos_p1);
    pad  = pad_q ? CMP_W'(b) : '0;
    room = size - pad;
    ok   = (pos_q != POS_MAX)
        && (size >= CMP_W'(RTP_FIXED_HDR_BYTES))
        && (size > CMP_W'(hdr) + pad)
        && (phase_upd != PH_WAIT_HDR)
        && (CMP_W'(dend_upd) <= room);
    len  = ok ? PW'(room - CMP_W'(dend_upd)) : '0;

    info_o.packet_ok      = ok;
    info_o.payload_start  = ok ? PAYLOAD_W'(dend_upd) : '0;
    info_o.payload_length = PAYLOAD_W'(len);
    info_o.first_hdr_ok   = size >= CMP_W'(RTP_FIXED_HDR_BYTES);
    info_o.capture_pt     = pos_q == PW'(PT_BYTE_POS);
    info_o.capture_ts     = (pos_q >= PW'(TS_FIRST_POS)) && (pos_q <= PW'(TS_LAST_POS));

    // clear at packet end, else advance and saturate
    if (word_i.end_of_packet) begin
      pos_d       = '0;
      csrc_d      = '0;
      ext_d       = 1'b0;
      pad_d       = 1'b0;
      ext_words_d = '0;
      phase_d     = PH_WAIT_HDR;
      dend_d      = '0;
    end else begin
      pos_d       = (pos_q != POS_MAX) ? pos_q + PW'(1) : pos_q;
      ext_words_d = ext_words_upd;
      phase_d     = phase_upd;
      dend_d      = dend_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      csrc_q      <= '0;
      ext_q       <= 1'b0;
      pad_q       <= 1'b0;
      ext_words_q <= '0;
      phase_q     <= PH_WAIT_HDR;
      dend_q      <= '0;
    end else if (advance_i) begin
      pos_q       <= pos_d;
      csrc_q      <= csrc_d;
      ext_q       <= ext_d;
      pad_q       <= pad_d;
      ext_words_q <= ext_words_d;
      phase_q     <= phase_d;
      dend_q      <= dend_d;
    end
  end

endmodule

// File: src/vrpe_frame_accum.sv
// ----------------------------------------------------------------------------
// VP8 RTP payload extent parser frame accumulator
// Latches the first packet's header fields, sums payload lengths and holds
// the result register.
// ----------------------------------------------------------------------------
module vrpe_frame_accum #(
  parameter int FRAME_LENGTH_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  vrpe_pkg::in_word_t  word_i,
  input  vrpe_pkg::pkt_info_t info_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output vrpe_pkg::out_word_t out_word_o,
  output logic                room_o
);
  import vrpe_pkg::*;

  localparam int FLW = FRAME_LENGTH_BITS;

  logic              first_pend_q, first_pend_d;
  logic              first_ok_q, first_ok_d;
  logic [TS_W-1:0]   ts_q, ts_d, ts_upd;
  logic [PT_W-1:0]   pt_q, pt_d, pt_upd;
  logic [FLW-1:0]    flen_q, flen_d, flen_upd;
  logic [FLW:0]      sum;
  logic              hdr_ok_upd;
  logic              fok;
  logic              load;
  logic              out_valid_q, out_valid_d;
  out_word_t         out_word_q, res;

  always_comb begin
    ts_upd = ts_q;
    pt_upd = pt_q;
    if (first_pend_q) begin
      if (info_i.capture_pt) begin
        pt_upd = word_i.data_byte[PT_W-1:0];
      end
      if (info_i.capture_ts) begin
        ts_upd = {ts_q[TS_W-BYTE_W-1:0], word_i.data_byte};
      end
    end

    hdr_ok_upd = first_pend_q ? info_i.first_hdr_ok : first_ok_q;
    sum        = {1'b0, flen_q} + (FLW+1)'(info_i.payload_length);
    flen_upd   = sum[FLW] ? '1 : sum[FLW-1:0];
    fok        = hdr_ok_upd && (flen_upd != '0);

    res.packet_ok          = info_i.packet_ok;
    res.payload_start      = info_i.payload_start;
    res.payload_length     = info_i.payload_length;
    res.frame_done         = word_i.end_of_frame;
    res.frame_ok           = word_i.end_of_frame && fok;
    res.frame_timestamp    = res.frame_ok ? ts_upd : '0;
    res.frame_payload_type = res.frame_ok ? pt_upd : '0;
    res.frame_length       = res.frame_ok ? FRAME_LEN_W'(flen_upd) : '0;

    load = advance_i && word_i.end_of_packet;

    first_pend_d = first_pend_q;
    first_ok_d   = first_ok_q;
    ts_d         = ts_upd;
    pt_d         = pt_upd;
    flen_d       = flen_q;
    if (word_i.end_of_packet) begin
      first_pend_d = 1'b0;
      first_ok_d   = hdr_ok_upd;
      flen_d       = flen_upd;
      if (word_i.end_of_frame) begin
        first_pend_d = 1'b1;
        first_ok_d   = 1'b0;
        ts_d         = '0;
        pt_d         = '0;
        flen_d       = '0;
      end
    end

    room_o = !out_valid_q || out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pend_q <= 1'b1;
      first_ok_q   <= 1'b0;
      ts_q         <= '0;
      pt_q         <= '0;
      flen_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_i) begin
        first_pend_q <= first_pend_d;
        first_ok_q   <= first_ok_d;
        ts_q         <= ts_d;
        pt_q         <= pt_d;
        flen_q       <= flen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
